// ===== hdl/mbsf_pkg.sv =====
package mbsf_pkg;

	localparam int unsigned HISTORY_DEPTH = 16;
	localparam int unsigned SIZE_W = 12;
	localparam int unsigned POS_W = 13;
	localparam int unsigned OUT_POS_W = 14;
	localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

	// per-cell insert control
	typedef struct packed {
		logic ins;   // an entry is being inserted this cycle
		logic occ;   // cell holds a value of the current run
		logic tail;  // cell is the first free one
	} mbsf_ctl_t;

endpackage

// ===== hdl/mbsf_cell.sv =====
module mbsf_cell
	import mbsf_pkg::*;
(
	input  logic              clk,
	input  mbsf_ctl_t         ctl,
	input  logic [SIZE_W-1:0] din,
	input  logic              prev_gt,
	input  logic [SIZE_W-1:0] prev_val,
	output logic              gt,
	output logic [SIZE_W-1:0] val
);

	logic [SIZE_W-1:0] val_q;

	// strictly greater: equal values stay ahead of the new one
	assign gt  = ctl.occ && (val_q > din);
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (prev_gt) begin
				val_q <= prev_val;
			end else if (gt || ctl.tail) begin
				val_q <= din;
			end
		end
	end

endmodule

// ===== hdl/median_box_size_filter_core.sv =====
// Result: taking the last item sets pend_s1, which registers the result strobe in strobe_q.
// Throughput: one item per cycle, every cycle; busy stays low.
// Insertion into the sorted cell rows finishes in the accepting cycle.
// Reset clears the entry count and the result valid flags; cell contents stay undefined.
// The receiver cannot stall: each result is shown for exactly one cycle.
module median_box_size_filter_core
	import mbsf_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [SIZE_W-1:0]           entry_width,
	input  logic [SIZE_W-1:0]           entry_height,
	input  logic                        entry_last,
	input  logic signed [POS_W-1:0]     box_left,
	input  logic signed [POS_W-1:0]     box_top,
	input  logic [SIZE_W-1:0]           box_span_x,
	input  logic [SIZE_W-1:0]           box_span_y,
	output logic                        strobe,
	output logic signed [OUT_POS_W-1:0] out_left,
	output logic signed [OUT_POS_W-1:0] out_top,
	output logic [SIZE_W-1:0]           out_span_x,
	output logic [SIZE_W-1:0]           out_span_y
);

	// ---------------------------------------------------------------
	// Item acceptance and run bookkeeping
	// ---------------------------------------------------------------
	logic             accept;
	logic             full;
	logic             ins;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] cnt_after;
	logic [CNT_W-1:0] cnt_half;
	logic [IDX_W-1:0] med_idx;

	// The median read happens in the cycle after the last item, from cell values
	// that the next run only starts to overwrite at the end of that cycle, so
	// nothing ever holds the sender off.
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(HISTORY_DEPTH));
	assign ins    = accept && !full;   // entries beyond the depth are dropped

	assign cnt_after = full ? count_q : (count_q + CNT_W'(1));
	assign cnt_half  = cnt_after >> 1;
	assign med_idx   = (cnt_half > CNT_W'(HISTORY_DEPTH - 1)) ?
		IDX_W'(HISTORY_DEPTH - 1) : cnt_half[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= entry_last ? '0 : cnt_after;
		end
	end

	// ---------------------------------------------------------------
	// Sorted cell rows: one for widths, one for heights. Each cell
	// compares the new item with its own value; cells above the
	// insert point take their lower neighbor's value.
	// ---------------------------------------------------------------
	logic [SIZE_W-1:0] w_val [HISTORY_DEPTH];
	logic [SIZE_W-1:0] h_val [HISTORY_DEPTH];
	logic              w_gt  [HISTORY_DEPTH];
	logic              h_gt  [HISTORY_DEPTH];

	for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
		mbsf_ctl_t         ctl;
		logic              w_prev_gt;
		logic              h_prev_gt;
		logic [SIZE_W-1:0] w_prev_val;
		logic [SIZE_W-1:0] h_prev_val;

		assign ctl.ins  = ins;
		assign ctl.occ  = (count_q > CNT_W'(i));
		assign ctl.tail = (count_q == CNT_W'(i));

		if (i == 0) begin : g_head
			assign w_prev_gt  = 1'b0;
			assign h_prev_gt  = 1'b0;
			assign w_prev_val = entry_width;
			assign h_prev_val = entry_height;
		end else begin : g_link
			assign w_prev_gt  = w_gt[i-1];
			assign h_prev_gt  = h_gt[i-1];
			assign w_prev_val = w_val[i-1];
			assign h_prev_val = h_val[i-1];
		end

		mbsf_cell u_w_cell (
			.clk      (clk),
			.ctl      (ctl),
			.din      (entry_width),
			.prev_gt  (w_prev_gt),
			.prev_val (w_prev_val),
			.gt       (w_gt[i]),
			.val      (w_val[i])
		);

		mbsf_cell u_h_cell (
			.clk      (clk),
			.ctl      (ctl),
			.din      (entry_height),
			.prev_gt  (h_prev_gt),
			.prev_val (h_prev_val),
			.gt       (h_gt[i]),
			.val      (h_val[i])
		);
	end

	// ---------------------------------------------------------------
	// Stage 1: latch the median index and the current box centre
	// ---------------------------------------------------------------
	logic                 pend_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [OUT_POS_W-1:0] cx_s1;
	logic [OUT_POS_W-1:0] cy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= accept && entry_last;
		end
	end

	// centre = edge + floor(span / 2), sign-extended to the output width
	always_ff @(posedge clk) begin
		if (accept && entry_last) begin
			idx_s1 <= med_idx;
			cx_s1  <= {box_left[POS_W-1], box_left} +
				{{(OUT_POS_W - SIZE_W + 1){1'b0}}, box_span_x[SIZE_W-1:1]};
			cy_s1  <= {box_top[POS_W-1], box_top} +
				{{(OUT_POS_W - SIZE_W + 1){1'b0}}, box_span_y[SIZE_W-1:1]};
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: pick the medians and place the box around the centre
	// ---------------------------------------------------------------
	logic [SIZE_W-1:0] med_w;
	logic [SIZE_W-1:0] med_h;
	logic              strobe_q;

	assign med_w = w_val[idx_s1];
	assign med_h = h_val[idx_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= pend_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			out_span_x <= med_w;
			out_span_y <= med_h;
			out_left   <= cx_s1 - {{(OUT_POS_W - SIZE_W + 1){1'b0}}, med_w[SIZE_W-1:1]};
			out_top    <= cy_s1 - {{(OUT_POS_W - SIZE_W + 1){1'b0}}, med_h[SIZE_W-1:1]};
		end
	end

	assign strobe = strobe_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(HISTORY_DEPTH))
		else $error("entry count beyond history depth");

	a_run_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && entry_last) |=> (count_q == '0))
		else $error("entry count not cleared at end of run");

	a_result_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && entry_last) |=> ##1 strobe)
		else $error("no result two cycles after last item");

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(pend_s1))
		else $error("result without a pending run end");

endmodule
